/* rtl/rsmac_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the matrix multiply-accumulate engine.
// Depends on nothing; every other file of the block uses it.
package rsmac_pkg;

    localparam int MEM_WORDS_DEF = 1024;
    localparam int DIM_W         = 11;
    localparam int CFG_IDX_W     = 3;
    localparam logic [DIM_W-1:0] DIM_MAX = 11'd1024;

    localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;
    localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;

    typedef enum logic [2:0] {
        OP_WRITE_A = 3'd0,
        OP_WRITE_B = 3'd1,
        OP_WRITE_C = 3'd2,
        OP_READ_C  = 3'd3,
        OP_RUN     = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        CFG_ROWS_M  = 3'd0,
        CFG_COLS_N  = 3'd1,
        CFG_INNER_K = 3'd2,
        CFG_A_PITCH = 3'd3,
        CFG_B_PITCH = 3'd4,
        CFG_C_PITCH = 3'd5
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDOUT,
        S_FETCH,
        S_MUL,
        S_MRND,
        S_ADD,
        S_ARND,
        S_STEP,
        S_DONE
    } state_t;

    // Unrounded result of a multiply or add, handed to the rounding unit.
    typedef struct packed {
        logic               special;
        logic [31:0]        spec_word;
        logic               sign;
        logic signed [11:0] exp;
        logic [47:0]        mant;
    } raw_t;

    function automatic logic is_nan(input logic [31:0] w);
        is_nan = (w[30:23] == 8'hFF) && (w[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(input logic [31:0] w);
        is_inf = (w[30:23] == 8'hFF) && (w[22:0] == 23'd0);
    endfunction

endpackage

/* rtl/row_stride_matmul_accumulate_core.sv */
`timescale 1ns / 1ps
// Matrix multiply-accumulate engine top level: stores, sequencer, float units.
// Depends on rsmac_pkg, rsmac_fmul, rsmac_fadd and rsmac_round.
// Writes are taken while idle; a read of C puts its word out in the cycle after acceptance.
// A run does M*N*K multiply-add steps (FETCH, MUL, MRND, ADD, ARND, STEP), then DONE;
// each C word is written back in its last step, and the shared rounding unit sets the pace.
// Results cannot be stalled. Reset clears config and sequencer registers, not the stores.
module row_stride_matmul_accumulate_core
#(
    parameter int MEM_WORDS = rsmac_pkg::MEM_WORDS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [2:0]                      opcode,
    input  logic [9:0]                      word_addr,
    input  logic [31:0]                     word_data,
    output logic                            result_valid,
    output logic                            result_kind,
    output logic [31:0]                     result_data,
    input  logic                            cfg_we,
    input  logic [rsmac_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rsmac_pkg::DIM_W-1:0]     cfg_data
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam int DW = rsmac_pkg::DIM_W;

    rsmac_pkg::state_t state_reg, state_next;

    logic [DW-1:0] rows_m_reg, cols_n_reg, inner_k_reg;
    logic [DW-1:0] a_pitch_reg, b_pitch_reg, c_pitch_reg;
    logic [DW-1:0] m_reg, m_next, n_reg, n_next, k_lim_reg, k_lim_next;
    logic [DW-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [AW-1:0] a_base_reg, a_base_next, c_base_reg, c_base_next;
    logic [AW-1:0] aa_reg, aa_next, ba_reg, ba_next, ca_reg, ca_next;
    logic [AW-1:0] in_addr;
    logic [AW-1:0] c_rd_addr;
    logic [DW-1:0] j_inc;
    logic          accept;
    logic          c_wr_run;

    logic [31:0] a_mem [MEM_WORDS];
    logic [31:0] b_mem [MEM_WORDS];
    logic [31:0] c_mem [MEM_WORDS];
    logic [31:0] a_q, b_q, c_q;
    logic [31:0] acc_reg;

    rsmac_pkg::raw_t mul_raw, add_raw, rnd_in;
    logic [31:0]     rnd_q;

    function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] d);
        clamp_dim = (d > rsmac_pkg::DIM_MAX) ? rsmac_pkg::DIM_MAX : d;
    endfunction

    assign accept   = start && !busy;
    assign in_addr  = AW'(word_addr);
    assign c_wr_run = (state_reg == rsmac_pkg::S_STEP) && (k_reg == k_lim_reg - DW'(1));
    assign j_inc    = j_reg + DW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_m_reg  <= '0;
            cols_n_reg  <= '0;
            inner_k_reg <= '0;
            a_pitch_reg <= '0;
            b_pitch_reg <= '0;
            c_pitch_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rsmac_pkg::CFG_ROWS_M:  rows_m_reg  <= cfg_data;
                rsmac_pkg::CFG_COLS_N:  cols_n_reg  <= cfg_data;
                rsmac_pkg::CFG_INNER_K: inner_k_reg <= cfg_data;
                rsmac_pkg::CFG_A_PITCH: a_pitch_reg <= cfg_data;
                rsmac_pkg::CFG_B_PITCH: b_pitch_reg <= cfg_data;
                rsmac_pkg::CFG_C_PITCH: c_pitch_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (opcode == rsmac_pkg::OP_WRITE_A))
        begin
            a_mem[in_addr] <= word_data;
        end
        if (state_reg == rsmac_pkg::S_FETCH)
        begin
            a_q <= a_mem[aa_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (opcode == rsmac_pkg::OP_WRITE_B))
        begin
            b_mem[in_addr] <= word_data;
        end
        if (state_reg == rsmac_pkg::S_FETCH)
        begin
            b_q <= b_mem[ba_reg];
        end
    end

    assign c_rd_addr = (state_reg == rsmac_pkg::S_IDLE) ? in_addr : ca_reg;

    always_ff @(posedge clk)
    begin
        if (accept && (opcode == rsmac_pkg::OP_WRITE_C))
        begin
            c_mem[in_addr] <= word_data;
        end
        else if (c_wr_run)
        begin
            c_mem[ca_reg] <= rnd_q;
        end
        if ((state_reg == rsmac_pkg::S_IDLE) || (state_reg == rsmac_pkg::S_FETCH))
        begin
            c_q <= c_mem[c_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == rsmac_pkg::S_MUL) && (k_reg == '0))
        begin
            acc_reg <= c_q;
        end
        else if (state_reg == rsmac_pkg::S_STEP)
        begin
            acc_reg <= rnd_q;
        end
    end

    rsmac_fmul u_fmul
    (
        .clk     (clk),
        .op_a    (a_q),
        .op_b    (b_q),
        .raw_out (mul_raw)
    );

    rsmac_fadd u_fadd
    (
        .clk     (clk),
        .op_a    (acc_reg),
        .op_b    (rnd_q),
        .raw_out (add_raw)
    );

    assign rnd_in = (state_reg == rsmac_pkg::S_ARND) ? add_raw : mul_raw;

    rsmac_round u_round
    (
        .clk      (clk),
        .raw_in   (rnd_in),
        .word_out (rnd_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rsmac_pkg::S_IDLE;
            m_reg      <= '0;
            n_reg      <= '0;
            k_lim_reg  <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
            a_base_reg <= '0;
            c_base_reg <= '0;
            aa_reg     <= '0;
            ba_reg     <= '0;
            ca_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            m_reg      <= m_next;
            n_reg      <= n_next;
            k_lim_reg  <= k_lim_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            k_reg      <= k_next;
            a_base_reg <= a_base_next;
            c_base_reg <= c_base_next;
            aa_reg     <= aa_next;
            ba_reg     <= ba_next;
            ca_reg     <= ca_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        m_next      = m_reg;
        n_next      = n_reg;
        k_lim_next  = k_lim_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        a_base_next = a_base_reg;
        c_base_next = c_base_reg;
        aa_next     = aa_reg;
        ba_next     = ba_reg;
        ca_next     = ca_reg;
        busy         = 1'b1;
        result_valid = 1'b0;
        result_kind  = 1'b0;
        result_data  = 32'd0;

        unique case (state_reg)
            rsmac_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (opcode == rsmac_pkg::OP_READ_C)
                    begin
                        state_next = rsmac_pkg::S_RDOUT;
                    end
                    else if (opcode == rsmac_pkg::OP_RUN)
                    begin
                        m_next      = clamp_dim(rows_m_reg);
                        n_next      = clamp_dim(cols_n_reg);
                        k_lim_next  = clamp_dim(inner_k_reg);
                        i_next      = '0;
                        j_next      = '0;
                        k_next      = '0;
                        a_base_next = '0;
                        c_base_next = '0;
                        aa_next     = '0;
                        ba_next     = '0;
                        ca_next     = '0;
                        if ((rows_m_reg == '0) || (cols_n_reg == '0) || (inner_k_reg == '0))
                        begin
                            state_next = rsmac_pkg::S_DONE;
                        end
                        else
                        begin
                            state_next = rsmac_pkg::S_FETCH;
                        end
                    end
                end
            end
            rsmac_pkg::S_RDOUT:
            begin
                result_valid = 1'b1;
                result_data  = c_q;
                state_next   = rsmac_pkg::S_IDLE;
            end
            rsmac_pkg::S_FETCH: state_next = rsmac_pkg::S_MUL;
            rsmac_pkg::S_MUL:   state_next = rsmac_pkg::S_MRND;
            rsmac_pkg::S_MRND:  state_next = rsmac_pkg::S_ADD;
            rsmac_pkg::S_ADD:   state_next = rsmac_pkg::S_ARND;
            rsmac_pkg::S_ARND:  state_next = rsmac_pkg::S_STEP;
            rsmac_pkg::S_STEP:
            begin
                state_next = rsmac_pkg::S_FETCH;
                if (k_reg == k_lim_reg - DW'(1))
                begin
                    k_next = '0;
                    if (j_reg == n_reg - DW'(1))
                    begin
                        j_next = '0;
                        if (i_reg == m_reg - DW'(1))
                        begin
                            state_next = rsmac_pkg::S_DONE;
                        end
                        else
                        begin
                            i_next      = i_reg + DW'(1);
                            a_base_next = a_base_reg + AW'(a_pitch_reg);
                            c_base_next = c_base_reg + AW'(c_pitch_reg);
                            aa_next     = a_base_reg + AW'(a_pitch_reg);
                            ba_next     = '0;
                            ca_next     = c_base_reg + AW'(c_pitch_reg);
                        end
                    end
                    else
                    begin
                        j_next  = j_inc;
                        aa_next = a_base_reg;
                        ba_next = AW'(j_inc);
                        ca_next = c_base_reg + AW'(j_inc);
                    end
                end
                else
                begin
                    k_next  = k_reg + DW'(1);
                    aa_next = aa_reg + AW'(1);
                    ba_next = ba_reg + AW'(b_pitch_reg);
                end
            end
            rsmac_pkg::S_DONE:
            begin
                result_valid = 1'b1;
                result_kind  = 1'b1;
                state_next   = rsmac_pkg::S_IDLE;
            end
            default: state_next = rsmac_pkg::S_IDLE;
        endcase
    end

endmodule

/* rtl/rsmac_fmul.sv */
`timescale 1ns / 1ps
// Binary32 multiply front end: special operands and the exact mantissa product.
// Depends on rsmac_pkg; the result goes to the shared rounding unit.
module rsmac_fmul
(
    input  logic                clk,
    input  logic [31:0]         op_a,
    input  logic [31:0]         op_b,
    output rsmac_pkg::raw_t     raw_out
);

    rsmac_pkg::raw_t raw_next;
    rsmac_pkg::raw_t raw_reg;
    logic [7:0]      ea;
    logic [7:0]      eb;
    logic [23:0]     ma;
    logic [23:0]     mb;
    logic            zero_a;
    logic            zero_b;

    always_comb
    begin
        ea     = (op_a[30:23] == 8'd0) ? 8'd1 : op_a[30:23];
        eb     = (op_b[30:23] == 8'd0) ? 8'd1 : op_b[30:23];
        ma     = {(op_a[30:23] != 8'd0), op_a[22:0]};
        mb     = {(op_b[30:23] != 8'd0), op_b[22:0]};
        zero_a = (op_a[30:0] == 31'd0);
        zero_b = (op_b[30:0] == 31'd0);

        raw_next.special   = 1'b0;
        raw_next.spec_word = 32'd0;
        raw_next.sign      = op_a[31] ^ op_b[31];
        raw_next.exp       = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd126;
        raw_next.mant      = ma * mb;

        if (rsmac_pkg::is_nan(op_a))
        begin
            raw_next.special   = 1'b1;
            raw_next.spec_word = op_a | rsmac_pkg::QUIET_BIT;
        end
        else if (rsmac_pkg::is_nan(op_b))
        begin
            raw_next.special   = 1'b1;
            raw_next.spec_word = op_b | rsmac_pkg::QUIET_BIT;
        end
        else if ((rsmac_pkg::is_inf(op_a) && zero_b) || (rsmac_pkg::is_inf(op_b) && zero_a))
        begin
            raw_next.special   = 1'b1;
            raw_next.spec_word = rsmac_pkg::QNAN_DEFAULT;
        end
        else if (rsmac_pkg::is_inf(op_a) || rsmac_pkg::is_inf(op_b))
        begin
            raw_next.special   = 1'b1;
            raw_next.spec_word = {op_a[31] ^ op_b[31], 8'hFF, 23'd0};
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg <= raw_next;
    end

    assign raw_out = raw_reg;

endmodule

/* rtl/rsmac_fadd.sv */
`timescale 1ns / 1ps
// Binary32 add front end: special operands, alignment and the mantissa sum.
// Depends on rsmac_pkg; the result goes to the shared rounding unit.
module rsmac_fadd
(
    input  logic                clk,
    input  logic [31:0]         op_a,
    input  logic [31:0]         op_b,
    output rsmac_pkg::raw_t     raw_out
);

    rsmac_pkg::raw_t raw_next;
    rsmac_pkg::raw_t raw_reg;
    logic [31:0]     x;
    logic [31:0]     y;
    logic [7:0]      ex;
    logic [7:0]      ey;
    logic [7:0]      shift_amt;
    logic [47:0]     xm;
    logic [47:0]     ym;
    logic [47:0]     ya;
    logic [47:0]     lost_mask;
    logic [47:0]     sum;

    always_comb
    begin
        if (op_a[30:0] >= op_b[30:0])
        begin
            x = op_a;
            y = op_b;
        end
        else
        begin
            x = op_b;
            y = op_a;
        end
        ex        = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey        = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        shift_amt = ex - ey;
        if (shift_amt > 8'd48)
        begin
            shift_amt = 8'd48;
        end
        xm        = {1'b0, (x[30:23] != 8'd0), x[22:0], 23'd0};
        ym        = {1'b0, (y[30:23] != 8'd0), y[22:0], 23'd0};
        lost_mask = ~({48{1'b1}} << shift_amt);
        ya        = (ym >> shift_amt) | {47'd0, |(ym & lost_mask)};
        sum       = (x[31] == y[31]) ? (xm + ya) : (xm - ya);

        raw_next.special   = 1'b0;
        raw_next.spec_word = 32'd0;
        raw_next.exp       = $signed({4'd0, ex}) + 12'sd1;
        raw_next.mant      = sum;
        if (sum == 48'd0)
        begin
            raw_next.sign = (x[31] == y[31]) ? x[31] : 1'b0;
        end
        else
        begin
            raw_next.sign = x[31];
        end

        if (rsmac_pkg::is_nan(op_a))
        begin
            raw_next.special   = 1'b1;
            raw_next.spec_word = op_a | rsmac_pkg::QUIET_BIT;
        end
        else if (rsmac_pkg::is_nan(op_b))
        begin
            raw_next.special   = 1'b1;
            raw_next.spec_word = op_b | rsmac_pkg::QUIET_BIT;
        end
        else if (rsmac_pkg::is_inf(op_a) && rsmac_pkg::is_inf(op_b) && (op_a[31] != op_b[31]))
        begin
            raw_next.special   = 1'b1;
            raw_next.spec_word = rsmac_pkg::QNAN_DEFAULT;
        end
        else if (rsmac_pkg::is_inf(op_a))
        begin
            raw_next.special   = 1'b1;
            raw_next.spec_word = op_a;
        end
        else if (rsmac_pkg::is_inf(op_b))
        begin
            raw_next.special   = 1'b1;
            raw_next.spec_word = op_b;
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg <= raw_next;
    end

    assign raw_out = raw_reg;

endmodule

/* rtl/rsmac_round.sv */
`timescale 1ns / 1ps
// Shared normalize and round-to-nearest-even unit for both multiply and add.
// Depends on rsmac_pkg for the unrounded result type.
module rsmac_round
(
    input  logic                clk,
    input  rsmac_pkg::raw_t     raw_in,
    output logic [31:0]         word_out
);

    logic [31:0]        word_next;
    logic [31:0]        word_reg;
    logic [5:0]         lz;
    logic [47:0]        norm;
    logic signed [11:0] e;
    logic [11:0]        sh;
    logic [47:0]        lost_mask;
    logic [7:0]         ef;
    logic [8:0]         ef2;
    logic               up;
    logic [24:0]        m25;

    always_comb
    begin
        lz = 6'd0;
        for (int b = 0; b < 48; b++)
        begin
            if (raw_in.mant[b])
            begin
                lz = 6'(47 - b);
            end
        end
        norm      = raw_in.mant << lz;
        e         = raw_in.exp - $signed({6'd0, lz});
        sh        = 12'd0;
        lost_mask = 48'd0;
        ef        = 8'd0;
        if (e < 12'sd1)
        begin
            sh = 12'(12'sd1 - e);
            if (sh > 12'd48)
            begin
                sh = 12'd48;
            end
            lost_mask = ~({48{1'b1}} << sh);
            norm      = (norm >> sh) | {47'd0, |(norm & lost_mask)};
        end
        else if (e > 12'sd254)
        begin
            ef = 8'hFF;
        end
        else
        begin
            ef = e[7:0];
        end
        up  = norm[23] & ((|norm[22:0]) | norm[24]);
        m25 = {1'b0, norm[47:24]} + {24'd0, up};
        ef2 = {1'b0, ef} + {8'd0, m25[24]};

        if (raw_in.special)
        begin
            word_next = raw_in.spec_word;
        end
        else if (raw_in.mant == 48'd0)
        begin
            word_next = {raw_in.sign, 31'd0};
        end
        else if (ef == 8'd0)
        begin
            word_next = {raw_in.sign, 7'd0, m25[23], m25[22:0]};
        end
        else if (ef2 >= 9'd255)
        begin
            word_next = {raw_in.sign, 8'hFF, 23'd0};
        end
        else
        begin
            word_next = {raw_in.sign, ef2[7:0], m25[24] ? 23'd0 : m25[22:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word_out = word_reg;

endmodule
